[rtl/fixed_point_pcm_quantizer_defines.svh]
// ============================================================================
// fixed_point_pcm_quantizer_defines.svh
// Assertion macros for the quantizer RTL.
// ============================================================================
`ifndef FIXED_POINT_PCM_QUANTIZER_DEFINES_SVH
`define FIXED_POINT_PCM_QUANTIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpq same-cycle check failed");

// next-cycle implication, disabled while in reset
`define FPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpq next-cycle check failed");

`endif

[rtl/fpq_pkg.sv]
// ============================================================================
// fpq_pkg
// Beat types, sequencer states and LCG constants for the PCM quantizer.
// ============================================================================
package fpq_pkg;

    localparam int PCM_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam logic [WORD_BITS-1:0] LCG_MUL = 32'h0019_660d;
    localparam logic [WORD_BITS-1:0] LCG_ADD = 32'h3c6e_f35f;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] left_sample;
        logic signed [WORD_BITS-1:0] right_sample;
        logic                        stereo;
    } in_beat_t;

    typedef struct packed {
        logic signed [PCM_BITS-1:0] left_pcm;
        logic signed [PCM_BITS-1:0] right_pcm;
    } out_beat_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] e_now;
        logic signed [WORD_BITS-1:0] e_half;
        logic signed [WORD_BITS-1:0] e_old;
        logic        [WORD_BITS-1:0] seed;
        logic        [WORD_BITS-1:0] rnd;
    } shape_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT
    } seq_state_t;

endpackage

[rtl/fpq_lane.sv]
// ============================================================================
// fpq_lane
// One channel quantizer: round-and-clip or noise-shaped dithered quantize.
// ============================================================================
module fpq_lane #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          mode,
    input  fpq_pkg::shape_state_t         st,
    input  logic signed [31:0]            sample,
    output logic signed [15:0]            pcm,
    output logic signed [31:0]            err
);
    import fpq_pkg::*;

    localparam int W = WORD_BITS + 4;
    localparam int S = FRAC_BITS + 1 - PCM_BITS;
    localparam logic signed [W-1:0] ONE   = W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0] HI    = ONE - W'(1);
    localparam logic signed [W-1:0] LO    = -ONE;
    localparam logic signed [W-1:0] BIAS  = W'(1) << (S - 1);
    localparam logic signed [W-1:0] RBIAS = W'(1) << (FRAC_BITS - PCM_BITS);

    logic signed [W-1:0] x;
    logic signed [W-1:0] en;
    logic signed [W-1:0] eh;
    logic signed [W-1:0] eo;
    logic signed [W-1:0] rd;
    logic signed [W-1:0] sd;
    logic signed [W-1:0] shaped;
    logic signed [W-1:0] dv;
    logic signed [W-1:0] xc;
    logic signed [W-1:0] oc;
    logic signed [W-1:0] q;
    logic signed [W-1:0] diff;
    logic signed [W-1:0] r;
    logic signed [W-1:0] rc;

    always_comb
    begin
        x  = {{(W-32){sample[31]}}, sample};
        en = {{(W-32){st.e_now[31]}}, st.e_now};
        eh = {{(W-32){st.e_half[31]}}, st.e_half};
        eo = {{(W-32){st.e_old[31]}}, st.e_old};
        rd = {{(W-S){1'b0}}, st.rnd[S-1:0]};
        sd = {{(W-S){1'b0}}, st.seed[S-1:0]};

        shaped = x + en - eh + eo;
        dv     = shaped + BIAS + rd - sd;

        if (dv > HI)
        begin
            oc = HI;
            xc = (shaped > HI) ? HI : shaped;
        end
        else if (dv < LO)
        begin
            oc = LO;
            xc = (shaped < LO) ? LO : shaped;
        end
        else
        begin
            oc = dv;
            xc = shaped;
        end

        q    = {oc[W-1:S], {S{1'b0}}};
        diff = xc - q;
        err  = diff[31:0];

        r = x + RBIAS;
        if (r > HI)
        begin
            rc = HI;
        end
        else if (r < LO)
        begin
            rc = LO;
        end
        else
        begin
            rc = r;
        end

        pcm = mode ? q[FRAC_BITS:S] : rc[FRAC_BITS:S];
    end

endmodule

[rtl/fpq_shape.sv]
// ============================================================================
// fpq_shape
// Shared noise-shaping error terms and dither generator for both lanes.
// ============================================================================
module fpq_shape (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic signed [31:0]    err,
    output fpq_pkg::shape_state_t st
);
    import fpq_pkg::*;

    logic signed [31:0] e_now_reg;
    logic signed [31:0] e_half_reg;
    logic signed [31:0] e_old_reg;
    logic        [31:0] seed_reg;
    logic        [31:0] rnd_reg;
    logic        [31:0] rnd_next;
    logic signed [32:0] half_sum;
    logic signed [31:0] half_next;

    always_comb
    begin
        rnd_next  = rnd_reg * LCG_MUL + LCG_ADD;
        half_sum  = {e_now_reg[31], e_now_reg} + {32'b0, e_now_reg[31]};
        half_next = half_sum[32:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_now_reg  <= '0;
            e_half_reg <= '0;
            e_old_reg  <= '0;
            seed_reg   <= '0;
            rnd_reg    <= LCG_ADD;
        end
        else if (advance)
        begin
            e_old_reg  <= e_half_reg;
            e_half_reg <= half_next;
            e_now_reg  <= err;
            seed_reg   <= rnd_reg;
            rnd_reg    <= rnd_next;
        end
    end

    assign st = '{e_now: e_now_reg, e_half: e_half_reg, e_old: e_old_reg,
                  seed: seed_reg, rnd: rnd_reg};

endmodule

[rtl/fixed_point_pcm_quantizer.sv]
// ============================================================================
// fixed_point_pcm_quantizer
// Stereo fixed-point to 16-bit PCM quantizer with noise-shaped dither.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | input     | in_valid / in_ready  | fpq_pkg::in_beat_t
//   out     | output    | out_valid / out_ready| fpq_pkg::out_beat_t
//   cfg     | input     | cfg_write            | cfg_data (quant_mode)
//
// Each beat runs the left lane in ST_LEFT, then the right lane in ST_RIGHT on
// the dither state the left lane left behind; that shared state sets the rate.
// Between an input beat and the output register lie hold_reg, ST_LEFT and ST_RIGHT.
// A stalled output holds the right lane; a new beat is taken as the result
// leaves the right lane. Reset clears error terms and seed to zero.
// ============================================================================
`include "fixed_point_pcm_quantizer_defines.svh"

module fixed_point_pcm_quantizer #(
    parameter int FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpq_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fpq_pkg::out_beat_t out_data,
    input  logic               cfg_write,
    input  logic               cfg_data
);
    import fpq_pkg::*;

    seq_state_t         state_reg;
    seq_state_t         state_next;
    in_beat_t           hold_reg;
    logic signed [15:0] left_pcm_reg;
    out_beat_t          out_data_reg;
    logic               out_valid_reg;
    logic               quant_mode_reg;

    logic               out_free;
    logic               finish;
    logic               advance;
    logic signed [31:0] adv_err;
    shape_state_t       shp;
    logic signed [15:0] pcm_l;
    logic signed [15:0] pcm_r;
    logic signed [31:0] err_l;
    logic signed [31:0] err_r;

    fpq_shape u_shape (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .err     (adv_err),
        .st      (shp)
    );

    fpq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_l (
        .mode   (quant_mode_reg),
        .st     (shp),
        .sample (hold_reg.left_sample),
        .pcm    (pcm_l),
        .err    (err_l)
    );

    fpq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .mode   (quant_mode_reg),
        .st     (shp),
        .sample (hold_reg.right_sample),
        .pcm    (pcm_r),
        .err    (err_r)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        finish     = 1'b0;
        advance    = 1'b0;
        adv_err    = err_l;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                advance    = quant_mode_reg;
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    in_ready   = 1'b1;
                    advance    = quant_mode_reg && hold_reg.stereo;
                    adv_err    = err_r;
                    state_next = in_valid ? ST_LEFT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            quant_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                quant_mode_reg <= cfg_data;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg <= in_data;
        end
        if (state_reg == ST_LEFT)
        begin
            left_pcm_reg <= pcm_l;
        end
        if (finish)
        begin
            out_data_reg.left_pcm  <= left_pcm_reg;
            out_data_reg.right_pcm <= hold_reg.stereo ? pcm_r : 16'sd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `FPQ_ASSERT_NEXT(a_left_then_right, clk, rst_n, state_reg == ST_LEFT, state_reg == ST_RIGHT)
    `FPQ_ASSERT_NEXT(a_finish_shows_beat, clk, rst_n, finish, out_valid_reg)
    `FPQ_ASSERT_NEXT(a_round_keeps_seed, clk, rst_n, state_reg == ST_LEFT && !quant_mode_reg, $stable(shp.seed))

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: PCM quantizer bench
// Sends stereo and mono frames of fixed-point samples in round-and-clip mode
// and in noise-shaped dither mode. Every frame is also run through a local
// model of the shaping filter, the dither generator and the clip paths. Each
// output beat is checked against the oldest expected PCM pair. Sender and
// receiver stalls are randomized over three pressure phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fpq_pkg::*;

    localparam int     FRAC_BITS  = 28;
    localparam int     SHIFT      = FRAC_BITS + 1 - PCM_BITS;
    localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;
    localparam longint CLIP_HI    = FULL_SCALE - 1;
    localparam longint CLIP_LO    = -FULL_SCALE;
    localparam longint STEP_MASK  = (longint'(1) << SHIFT) - 1;
    localparam logic [31:0] SEED_MASK = (32'd1 << SHIFT) - 1;
    localparam bit     MODE_ROUND  = 1'b0;
    localparam bit     MODE_DITHER = 1'b1;
    localparam int     DIR_ROWS   = 21;
    localparam int     BLOCK_LEN  = 75;
    localparam int     BLOCKS     = 6;

    typedef struct {
        bit          qmode;
        logic [31:0] lsmp;
        logic [31:0] rsmp;
        bit          stereo;
        bit          typed;
        logic [15:0] lexp;
        logic [15:0] rexp;
    } vec_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    logic      cfg_write = 1'b0;
    logic      cfg_data  = 1'b0;

    out_beat_t frame_expected[$];

    bit                 cur_mode;
    logic signed [31:0] err_now;
    logic signed [31:0] err_half;
    logic signed [31:0] err_old;
    logic        [31:0] dither_seed;

    int send_idle;
    int recv_idle;
    int err_count;
    int n_frames;
    int n_dither;
    int n_mono;
    int n_cfg;
    int n_checked;

    vec_row_t dir_rows [DIR_ROWS] = '{
        '{MODE_ROUND,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
        '{MODE_ROUND,  32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1, 16'h7fff, 16'h8000},
        '{MODE_ROUND,  32'h1000_0000, 32'hf000_0000, 1'b1, 1'b1, 16'h7fff, 16'h8000},
        '{MODE_ROUND,  32'h0000_2000, 32'hffff_ffff, 1'b1, 1'b1, 16'h0001, 16'h0000},
        '{MODE_ROUND,  32'hffff_efff, 32'hffff_f000, 1'b1, 1'b1, 16'hffff, 16'h0000},
        '{MODE_ROUND,  32'h7fff_ffff, 32'h1234_5678, 1'b0, 1'b1, 16'h7fff, 16'h0000},
        '{MODE_ROUND,  32'h0fff_efff, 32'hf000_1000, 1'b1, 1'b1, 16'h7fff, 16'h8001},
        '{MODE_ROUND,  32'h0fff_e000, 32'h0000_0fff, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0fff_ffff, 32'hf000_0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0000_1000, 32'hffff_efff, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0fff_f000, 32'hf000_0800, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
        '{MODE_DITHER, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_ROUND,  32'h0fff_f000, 32'h0000_0fff, 1'b1, 1'b0, 16'h0000, 16'h0000},
        '{MODE_ROUND,  32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b1, 16'h8000, 16'h7fff},
        '{MODE_DITHER, 32'h0123_4567, 32'hfedc_ba98, 1'b1, 1'b0, 16'h0000, 16'h0000}
    };

    fixed_point_pcm_quantizer #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] round_lane(input logic signed [31:0] raw);
        longint v;
        v = raw;
        v = v + (longint'(1) << (FRAC_BITS - PCM_BITS));
        if (v > CLIP_HI)
            v = CLIP_HI;
        else if (v < CLIP_LO)
            v = CLIP_LO;
        v = v >>> SHIFT;
        return v[15:0];
    endfunction

    function automatic logic [15:0] dither_lane(input logic signed [31:0] raw);
        longint      shaped;
        longint      q;
        longint      e0;
        longint      e1;
        longint      e2;
        longint      resid;
        logic [31:0] nxt;
        shaped = raw;
        e0 = err_now;
        e1 = err_half;
        e2 = err_old;
        shaped = shaped + e0 - e1 + e2;
        err_old = e1[31:0];
        e0 = e0 / 2;
        err_half = e0[31:0];

        q = shaped + (longint'(1) << (SHIFT - 1));
        nxt = dither_seed * LCG_MUL + LCG_ADD;
        q = q + longint'(nxt & SEED_MASK) - longint'(dither_seed & SEED_MASK);
        dither_seed = nxt;

        if (q > CLIP_HI) begin
            q = CLIP_HI;
            if (shaped > CLIP_HI)
                shaped = CLIP_HI;
        end
        else if (q < CLIP_LO) begin
            q = CLIP_LO;
            if (shaped < CLIP_LO)
                shaped = CLIP_LO;
        end

        q = q - (q & STEP_MASK);
        resid = shaped - q;
        err_now = resid[31:0];
        q = q >>> SHIFT;
        return q[15:0];
    endfunction

    function automatic logic [15:0] pcm_lane(input logic signed [31:0] raw);
        if (cur_mode == MODE_DITHER)
            return dither_lane(raw);
        return round_lane(raw);
    endfunction

    function automatic out_beat_t predict_frame(input in_beat_t b);
        out_beat_t r;
        r.left_pcm = pcm_lane(b.left_sample);
        if (b.stereo)
            r.right_pcm = pcm_lane(b.right_sample);
        else
            r.right_pcm = '0;
        return r;
    endfunction

    function automatic logic [31:0] draw_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            1: r = {{3{r[28]}}, r[28:0]};
            2: r = (r[0] ? 32'h1000_0000 : 32'hf000_0000) + {{18{r[14]}}, r[14:1]};
            3: r = {{17{r[15]}}, r[15:1]};
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_frame(input in_beat_t b, input bit use_typed, input out_beat_t typed_val);
        out_beat_t want;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_frame(b);
        if (use_typed)
            want = typed_val;
        frame_expected.push_back(want);
        n_frames++;
        if (cur_mode == MODE_DITHER)
            n_dither++;
        if (!b.stereo)
            n_mono++;
        @(negedge clk);
    endtask

    task automatic set_mode(input bit m);
        in_valid <= 1'b0;
        while (frame_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        cur_mode = m;
        n_cfg++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk) begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (frame_expected.size() == 0) begin
                if (err_count < 10)
                    $display("%0t: unexpected beat L=%h R=%h", $realtime,
                             out_data.left_pcm, out_data.right_pcm);
                err_count++;
            end
            else begin
                want = frame_expected.pop_front();
                n_checked++;
                if (out_data.left_pcm !== want.left_pcm ||
                    out_data.right_pcm !== want.right_pcm) begin
                    if (err_count < 10)
                        $display("%0t: beat %0d mismatch L exp %h got %h, R exp %h got %h",
                                 $realtime, n_checked, want.left_pcm, out_data.left_pcm,
                                 want.right_pcm, out_data.right_pcm);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        in_beat_t  b;
        out_beat_t t;
        cur_mode    = MODE_ROUND;
        err_now     = '0;
        err_half    = '0;
        err_old     = '0;
        dither_seed = '0;
        send_idle   = 7;
        recv_idle   = 82;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_mode(MODE_ROUND);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].qmode != cur_mode)
                set_mode(dir_rows[i].qmode);
            b.left_sample  = dir_rows[i].lsmp;
            b.right_sample = dir_rows[i].rsmp;
            b.stereo       = dir_rows[i].stereo;
            t.left_pcm     = dir_rows[i].lexp;
            t.right_pcm    = dir_rows[i].rexp;
            push_frame(b, dir_rows[i].typed, t);
        end

        t = '0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 7;  recv_idle = 82; end
                1: begin send_idle = 82; recv_idle = 7;  end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                set_mode((blk % 3 != 1) ? MODE_DITHER : MODE_ROUND);
                for (int k = 0; k < BLOCK_LEN; k++) begin
                    b.left_sample  = draw_sample();
                    b.right_sample = draw_sample();
                    b.stereo       = ($urandom_range(3) != 0);
                    push_frame(b, 1'b0, t);
                end
            end
        end

        in_valid <= 1'b0;
        while (frame_expected.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d frames: %0d noise-shaped, %0d mono, %0d mode writes",
                 n_frames, n_dither, n_mono, n_cfg);
        $display("checked %0d output beats across three stall patterns", n_checked);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
